// ----- hdl/mexp_pkg.sv -----
`timescale 1ns / 1ps

package mexp_pkg;

    // Operand width of base, exponent, modulus and result.
    localparam int OPERAND_WIDTH = 63;
    // Step counter width for one serial modular product.
    localparam int COUNT_WIDTH = $clog2(OPERAND_WIDTH);

    typedef logic [OPERAND_WIDTH-1:0] operand_t;
    typedef logic [COUNT_WIDTH-1:0]   step_count_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MULT,
        ST_FINISH
    } mexp_state_t;

    // (a + b) mod m for a, b < m: one add, then one trial subtract.
    function automatic operand_t add_reduce(operand_t a, operand_t b, operand_t m);
        logic [OPERAND_WIDTH:0]   sum;
        logic [OPERAND_WIDTH+1:0] diff;
        sum  = {1'b0, a} + {1'b0, b};
        diff = {1'b0, sum} - {2'b00, m};
        return diff[OPERAND_WIDTH+1] ? sum[OPERAND_WIDTH-1:0] : diff[OPERAND_WIDTH-1:0];
    endfunction

endpackage

// ----- hdl/mexp_mulmod.sv -----
`timescale 1ns / 1ps

// Serial modular multiplier: x * y mod m by right-to-left double-and-add.
// The multiplier y shifts out one bit per cycle; x must be below m, y may
// be any operand value. After a step for every multiplier bit, done
// pulses for one cycle with the product on product.
module mexp_mulmod (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  mexp_pkg::operand_t  x,
    input  mexp_pkg::operand_t  y,
    input  mexp_pkg::operand_t  m,
    output logic                done,
    output mexp_pkg::operand_t  product
);

    mexp_pkg::operand_t    acc_reg;
    mexp_pkg::operand_t    addend_reg;
    mexp_pkg::operand_t    mult_reg;
    mexp_pkg::operand_t    mod_reg;
    mexp_pkg::step_count_t count_reg;
    logic                  busy_reg;
    logic                  done_reg;

    mexp_pkg::operand_t    acc_next;
    mexp_pkg::operand_t    addend_next;

    // One double-and-add step on the current low bit of the multiplier.
    always_comb begin
        acc_next    = mult_reg[0] ? mexp_pkg::add_reduce(acc_reg, addend_reg, mod_reg)
                                  : acc_reg;
        addend_next = mexp_pkg::add_reduce(addend_reg, addend_reg, mod_reg);
    end

    // Control: busy for one step per multiplier bit, then a one-cycle done.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && count_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: operands load on start, then shift and accumulate.
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg    <= '0;
            addend_reg <= x;
            mult_reg   <= y;
            mod_reg    <= m;
            count_reg  <= mexp_pkg::step_count_t'(mexp_pkg::OPERAND_WIDTH - 1);
        end else if (busy_reg) begin
            acc_reg    <= acc_next;
            addend_reg <= addend_next;
            mult_reg   <= mult_reg >> 1;
            count_reg  <= count_reg - 1'b1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- hdl/modular_exponentiation.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Ports                                    Meaning
// s_        in         s_base_value, s_exponent, s_modulus      one exponentiation request
// m_        out        m_power_result, m_zero_modulus_error     base^exponent mod modulus
//
// Sequence: a zero modulus goes straight to the finish state. Otherwise
// the base is first reduced in one serial product, then each exponent bit
// up to its highest set bit costs one step state and one serial product on
// both multipliers in parallel. The bit-serial modular multipliers take one
// multiplier bit per cycle. Reset is synchronous and active low; it empties
// the sequencer and the result register. A stalled result holds the next
// item in its final state; a new item is taken once the sequencer is idle.
module modular_exponentiation (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mexp_pkg::operand_t s_base_value,
    input  mexp_pkg::operand_t s_exponent,
    input  mexp_pkg::operand_t s_modulus,
    output logic               m_valid,
    input  logic               m_ready,
    output mexp_pkg::operand_t m_power_result,
    output logic               m_zero_modulus_error
);

    mexp_pkg::mexp_state_t state_reg;
    mexp_pkg::mexp_state_t state_next;

    mexp_pkg::operand_t exp_reg;
    mexp_pkg::operand_t mod_reg;
    mexp_pkg::operand_t acc_reg;
    mexp_pkg::operand_t sq_reg;
    logic               err_reg;

    logic               m_valid_reg;
    mexp_pkg::operand_t result_reg;
    logic               result_err_reg;

    logic               start_a;
    logic               start_b;
    logic               out_load;
    logic               out_free;
    logic               exp_zero;
    logic               s_mod_zero;
    mexp_pkg::operand_t s_one;
    mexp_pkg::operand_t a_x;
    mexp_pkg::operand_t a_y;
    mexp_pkg::operand_t a_m;
    mexp_pkg::operand_t a_prod;
    mexp_pkg::operand_t b_prod;
    logic               a_done;
    logic               b_done;

    assign out_free   = !m_valid_reg || m_ready;
    assign exp_zero   = (exp_reg == '0);
    assign s_mod_zero = (s_modulus == '0);
    // 1 mod m: zero for a modulus of zero or one.
    assign s_one      = (s_modulus > mexp_pkg::operand_t'(1)) ? mexp_pkg::operand_t'(1) : '0;

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mexp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_mod_zero ? mexp_pkg::ST_FINISH : mexp_pkg::ST_REDUCE;
                end
            end
            mexp_pkg::ST_REDUCE: begin
                if (a_done) begin
                    state_next = mexp_pkg::ST_STEP;
                end
            end
            mexp_pkg::ST_STEP: begin
                state_next = exp_zero ? mexp_pkg::ST_FINISH : mexp_pkg::ST_MULT;
            end
            mexp_pkg::ST_MULT: begin
                if (a_done && b_done) begin
                    state_next = mexp_pkg::ST_STEP;
                end
            end
            mexp_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = mexp_pkg::ST_IDLE;
                end
            end
            default: state_next = mexp_pkg::ST_IDLE;
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        s_ready  = 1'b0;
        start_a  = 1'b0;
        start_b  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            mexp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                start_a = s_valid && !s_mod_zero;
            end
            mexp_pkg::ST_STEP: begin
                start_a = !exp_zero;
                start_b = !exp_zero;
            end
            mexp_pkg::ST_FINISH: begin
                out_load = out_free;
            end
            mexp_pkg::ST_REDUCE, mexp_pkg::ST_MULT: begin
                s_ready = 1'b0;
            end
            default: s_ready = 1'b0;
        endcase
    end

    // Multiplier A reduces the base (1 * base mod m) on a transfer, and
    // forms acc * sq in each exponent step.
    always_comb begin
        if (state_reg == mexp_pkg::ST_IDLE) begin
            a_x = s_one;
            a_y = s_base_value;
            a_m = s_modulus;
        end else begin
            a_x = acc_reg;
            a_y = sq_reg;
            a_m = mod_reg;
        end
    end

    mexp_mulmod u_mul_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_a),
        .x       (a_x),
        .y       (a_y),
        .m       (a_m),
        .done    (a_done),
        .product (a_prod)
    );

    // Multiplier B squares sq alongside A.
    mexp_mulmod u_mul_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_b),
        .x       (sq_reg),
        .y       (sq_reg),
        .m       (mod_reg),
        .done    (b_done),
        .product (b_prod)
    );

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mexp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Working registers: latch the request, then update per exponent bit.
    always_ff @(posedge aclk) begin
        if (state_reg == mexp_pkg::ST_IDLE && s_valid) begin
            exp_reg <= s_exponent;
            mod_reg <= s_modulus;
            acc_reg <= s_one;
            err_reg <= s_mod_zero;
        end else if (state_reg == mexp_pkg::ST_REDUCE && a_done) begin
            sq_reg <= a_prod;
        end else if (state_reg == mexp_pkg::ST_MULT && a_done && b_done) begin
            if (exp_reg[0]) begin
                acc_reg <= a_prod;
            end
            sq_reg  <= b_prod;
            exp_reg <= exp_reg >> 1;
        end
    end

    // Result register: holds a finished result until its transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            result_reg     <= acc_reg;
            result_err_reg <= err_reg;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_power_result       = result_reg;
    assign m_zero_modulus_error = result_err_reg;

endmodule

// ----- hdl/mexp_checker.sv -----
`timescale 1ns / 1ps

module mexp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input mexp_pkg::operand_t s_base_value,
    input mexp_pkg::operand_t s_exponent,
    input mexp_pkg::operand_t s_modulus,
    input logic               m_valid,
    input logic               m_ready,
    input mexp_pkg::operand_t m_power_result,
    input logic               m_zero_modulus_error
);

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_power_result)
            && $stable(m_zero_modulus_error))
        else $error("result changed while stalled");

    // An error result always carries zero.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_modulus_error |-> m_power_result == '0)
        else $error("error result is not zero");

    // One request at a time: no transfer right after a transfer.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // A request with a zero modulus is reported as soon as the result register is free.
    a_zero_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_modulus == '0 ##1 (!m_valid || m_ready)
            |=> m_valid && m_zero_modulus_error)
        else $error("zero modulus not reported");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);
